[hw/rtl/ifs_pkg.sv]
// Package for the image format sniffer: payload types, format and mode codes.
`default_nettype none
package ifs_pkg;

   localparam int TagScanWindowDefault = 256;
   localparam int HeaderBytesDefault   = 30;

   typedef enum logic [3:0] {
      IMG_UNKNOWN = 4'd0,
      IMG_PNG     = 4'd1,
      IMG_JPEG    = 4'd2,
      IMG_WEBP    = 4'd3,
      IMG_BMP     = 4'd4,
      IMG_GIF     = 4'd5,
      IMG_TIFF    = 4'd6,
      IMG_ICO     = 4'd7,
      IMG_SVG     = 4'd8
   } img_type_type;

   typedef enum logic [2:0] {
      MODE_NONE     = 3'd0,
      MODE_BASELINE = 3'd1,
      MODE_PROGRESS = 3'd2,
      MODE_EXTSEQ   = 3'd3,
      MODE_OTHER    = 3'd4
   } jpeg_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  img_type;
      logic [2:0]  jpeg_mode;
      logic [31:0] width;
      logic [31:0] height;
   } rsp_word_type;

   // Classify a JPEG start-of-frame marker code; zero when not an SOF.
   function automatic logic [2:0] sof_class(input logic [7:0] m);
      logic sof;
      logic [2:0] r;
      sof = (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
            (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
      if (!sof)                         r = MODE_NONE;
      else if (m == 8'hC0)              r = MODE_BASELINE;
      else if (m == 8'hC2 || m == 8'hCA) r = MODE_PROGRESS;
      else if (m == 8'hC1 || m == 8'hC9) r = MODE_EXTSEQ;
      else                              r = MODE_OTHER;
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/image_format_sniffer.sv]
// Image format sniffer top level: byte-stream header scanner and classifier.
//
// Usage: an image file enters on the req_ channel one word (one byte plus a
// last flag) per cycle unless req stall is high. For every file the block
// emits exactly one word on the rsp_ channel, caused by the byte flagged
// last: the format code, the JPEG coding mode and the width and height read
// from the header. Throughput is one byte per cycle while req stall is low;
// every byte is handled by short compare and counter logic in the same cycle
// it is accepted. The result word is held in an output register and appears
// in the cycle after the last byte is accepted. The walk state is reset right
// after the last byte, so the next file may follow in the very next cycle.
// When the receiver stalls while a result is pending, the block still takes
// bytes until another last byte arrives; only that byte is held back (req
// stall goes high) until the pending result has been taken.
// A synchronous active-high reset clears all walk state and the output valid.
// The first HEADER_BYTES bytes are kept in a small register store; JPEG
// segments are walked with a 16-bit skip counter, and the first
// TAG_SCAN_WINDOW - 1 bytes are searched for an SVG opening tag.
`default_nettype none
module image_format_sniffer
   import ifs_pkg::*;
#(
   parameter int TAG_SCAN_WINDOW = TagScanWindowDefault,
   parameter int HEADER_BYTES    = HeaderBytesDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int PosLimit = (TAG_SCAN_WINDOW > 510) ? TAG_SCAN_WINDOW + 1 : 511;
   localparam int PosW     = $clog2(PosLimit + 1);
   localparam int HdrW     = $clog2(HEADER_BYTES);

   typedef enum logic [2:0] {
      PH_SEEK, PH_FFRUN, PH_LENHI, PH_LENLO, PH_SKIP, PH_FRAME
   } phase_type;

   logic [7:0]     hdr_ff [HEADER_BYTES];
   logic [PosW-1:0] pos_ff, pos_in;
   phase_type      phase_ff, phase_in;
   logic [15:0]    skip_ff, skip_in;
   logic [7:0]     lenhi_ff, lenhi_in;
   logic [2:0]     fidx_ff, fidx_in;
   logic [2:0]     mode_ff, mode_in;
   logic [15:0]    fh_ff, fh_in, fw_ff, fw_in;
   logic           done_ff, done_in;
   logic [23:0]    twin_ff, twin_in;
   logic           tpend_ff, tpend_in, tfound_ff, tfound_in;
   logic           rsp_valid_ff;
   rsp_word_type   rsp_ff, rsp_in;

   logic           accept;
   logic [7:0]     b;
   logic [31:0]    tword;
   logic [PosW-1:0] n;

   assign req_stall = rsp_valid_ff && rsp_stall && req_word.last;
   assign accept    = req_valid && !req_stall;
   assign b         = req_word.data_byte;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Header byte i including the byte arriving now (classification happens
   // on the same edge that stores the last byte).
   function automatic logic [7:0] hb(input int i);
      logic [7:0] r;
      r = 8'h00;
      if (i < HEADER_BYTES) begin
         if (int'(pos_ff) == i) r = b;
         else                   r = hdr_ff[i];
      end
      return r;
   endfunction

   // JPEG walk and tag window next state.
   always_comb begin
      logic [15:0] seg;
      phase_in = phase_ff;
      skip_in  = skip_ff;
      lenhi_in = lenhi_ff;
      fidx_in  = fidx_ff;
      mode_in  = mode_ff;
      fh_in    = fh_ff;
      fw_in    = fw_ff;
      done_in  = done_ff;
      seg      = {lenhi_ff, b};
      if (pos_ff >= PosW'(2) && !done_ff) begin
         unique case (phase_ff)
            PH_SEEK: if (b == 8'hFF) phase_in = PH_FFRUN;
            PH_FFRUN: begin
               if (b != 8'hFF) begin
                  mode_in = sof_class(b);
                  if (b == 8'hD9 || b == 8'hDA) done_in = 1'b1;
                  else if (b == 8'hD8 || (b >= 8'hD0 && b <= 8'hD7) || b == 8'h00)
                     phase_in = PH_SEEK;
                  else phase_in = PH_LENHI;
               end
            end
            PH_LENHI: begin
               lenhi_in = b;
               phase_in = PH_LENLO;
            end
            PH_LENLO: begin
               if (seg < 16'd2) begin
                  mode_in = MODE_NONE;
                  done_in = 1'b1;
               end else if (mode_ff != MODE_NONE) begin
                  fidx_in  = 3'd0;
                  phase_in = PH_FRAME;
               end else begin
                  skip_in  = seg - 16'd2;
                  phase_in = (seg != 16'd2) ? PH_SKIP : PH_SEEK;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) phase_in = PH_SEEK;
            end
            PH_FRAME: begin
               if (fidx_ff == 3'd1) fh_in = {b, 8'h00};
               else if (fidx_ff == 3'd2) fh_in = fh_ff | {8'h00, b};
               else if (fidx_ff == 3'd3) fw_in = {b, 8'h00};
               else if (fidx_ff == 3'd4) fw_in = fw_ff | {8'h00, b};
               fidx_in = fidx_ff + 3'd1;
               if (fidx_ff >= 3'd4) done_in = 1'b1;
            end
            default: done_in = 1'b1;
         endcase
      end
      tfound_in = tfound_ff | tpend_ff;
      tword     = {twin_ff, b};
      tpend_in  = (tword == 32'h3C737667 || tword == 32'h3C535647) &&
                  (32'(pos_ff) + 32'd1 < 32'(TAG_SCAN_WINDOW));
      twin_in   = tword[23:0];
      n         = (pos_ff < PosW'(PosLimit)) ? pos_ff + PosW'(1) : PosW'(PosLimit);
      pos_in    = n;
   end

   // Classification of the completed file.
   always_comb begin
      logic [31:0] w, h, raw;
      logic [3:0]  t;
      logic [2:0]  m;
      logic        png, riff;
      logic [7:0]  b22, b24, b27, b29;
      w = '0; h = '0; raw = '0; t = IMG_UNKNOWN; m = MODE_NONE;
      b22 = hb(22);
      b24 = hb(24);
      b27 = hb(27);
      b29 = hb(29);
      png = hb(0) == 8'h89 && hb(1) == 8'h50 && hb(2) == 8'h4E && hb(3) == 8'h47 &&
            hb(4) == 8'h0D && hb(5) == 8'h0A && hb(6) == 8'h1A && hb(7) == 8'h0A;
      riff = hb(0) == "R" && hb(1) == "I" && hb(2) == "F" && hb(3) == "F" &&
             hb(8) == "W" && hb(9) == "E" && hb(10) == "B" && hb(11) == "P";
      if (n < PosW'(4)) begin
         t = IMG_UNKNOWN;
      end else if (n >= PosW'(8) && png) begin
         t = IMG_PNG;
         if (n >= PosW'(24) && hb(12) == "I" && hb(13) == "H" && hb(14) == "D" &&
             hb(15) == "R") begin
            w = {hb(16), hb(17), hb(18), hb(19)};
            h = {hb(20), hb(21), hb(22), hb(23)};
         end
      end else if (hb(0) == 8'hFF && hb(1) == 8'hD8 && hb(2) == 8'hFF) begin
         t = IMG_JPEG;
         m = (mode_in != MODE_NONE && phase_in != PH_LENHI && phase_in != PH_LENLO)
             ? mode_in : MODE_OTHER;
         if ((m != MODE_OTHER || mode_in == MODE_OTHER) && phase_in == PH_FRAME &&
             fidx_in >= 3'd5) begin
            w = {16'h0, fw_in};
            h = {16'h0, fh_in};
         end
      end else if (n >= PosW'(12) && riff) begin
         t = IMG_WEBP;
         if (n >= PosW'(30) && hb(12) == "V" && hb(13) == "P" && hb(14) == "8" &&
             hb(15) == " ") begin
            w = {18'h0, b27[5:0], hb(26)};
            h = {18'h0, b29[5:0], hb(28)};
         end else if (n >= PosW'(25) && hb(12) == "V" && hb(13) == "P" &&
                      hb(14) == "8" && hb(15) == "L" && hb(20) == 8'h2F) begin
            w = 32'd1 + {18'h0, b22[5:0], hb(21)};
            h = 32'd1 + {18'h0, b24[3:0], hb(23), b22[7:6]};
         end else if (n >= PosW'(30) && hb(12) == "V" && hb(13) == "P" &&
                      hb(14) == "8" && hb(15) == "X") begin
            w = 32'd1 + {8'h0, hb(26), hb(25), hb(24)};
            h = 32'd1 + {8'h0, hb(29), hb(28), hb(27)};
         end
      end else if (hb(0) == 8'h42 && hb(1) == 8'h4D) begin
         t = IMG_BMP;
         if (n >= PosW'(26)) begin
            raw = {hb(25), hb(24), hb(23), hb(22)};
            w   = {hb(21), hb(20), hb(19), hb(18)};
            h   = raw[31] ? (32'd0 - raw) : raw;
         end
      end else if (n >= PosW'(10) && hb(0) == "G" && hb(1) == "I" && hb(2) == "F" &&
                   hb(3) == "8" && (hb(4) == "7" || hb(4) == "9") && hb(5) == "a") begin
         t = IMG_GIF;
         w = {16'h0, hb(7), hb(6)};
         h = {16'h0, hb(9), hb(8)};
      end else if ((hb(0) == 8'h49 && hb(1) == 8'h49 && hb(2) == 8'h2A && hb(3) == 8'h00) ||
                   (hb(0) == 8'h4D && hb(1) == 8'h4D && hb(2) == 8'h00 &&
                    hb(3) == 8'h2A)) begin
         t = IMG_TIFF;
      end else if (n >= PosW'(6) && hb(0) == 8'h00 && hb(1) == 8'h00 && hb(2) == 8'h01 &&
                   hb(3) == 8'h00) begin
         t = IMG_ICO;
         if (n >= PosW'(8)) begin
            w = (hb(6) == 8'h00) ? 32'd256 : {24'h0, hb(6)};
            h = (hb(7) == 8'h00) ? 32'd256 : {24'h0, hb(7)};
         end
      end else if (tfound_in) begin
         t = IMG_SVG;
      end
      rsp_in.img_type  = t;
      rsp_in.jpeg_mode = m;
      rsp_in.width     = w;
      rsp_in.height    = h;
   end

   always_ff @(posedge clock) begin
      if (accept && pos_ff < PosW'(HEADER_BYTES)) hdr_ff[HdrW'(pos_ff)] <= b;
      if (accept && req_word.last) rsp_ff <= rsp_in;
      if (reset) begin
         pos_ff <= '0; phase_ff <= PH_SEEK; skip_ff <= '0; lenhi_ff <= '0;
         fidx_ff <= '0; mode_ff <= MODE_NONE; fh_ff <= '0; fw_ff <= '0;
         done_ff <= 1'b0; twin_ff <= '0; tpend_ff <= 1'b0; tfound_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept && req_word.last) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)        rsp_valid_ff <= 1'b0;
         if (accept) begin
            if (req_word.last) begin
               pos_ff <= '0; phase_ff <= PH_SEEK; skip_ff <= '0; lenhi_ff <= '0;
               fidx_ff <= '0; mode_ff <= MODE_NONE; fh_ff <= '0; fw_ff <= '0;
               done_ff <= 1'b0; twin_ff <= '0; tpend_ff <= 1'b0; tfound_ff <= 1'b0;
            end else begin
               pos_ff <= pos_in; phase_ff <= phase_in; skip_ff <= skip_in;
               lenhi_ff <= lenhi_in; fidx_ff <= fidx_in; mode_ff <= mode_in;
               fh_ff <= fh_in; fw_ff <= fw_in; done_ff <= done_in;
               twin_ff <= twin_in; tpend_ff <= tpend_in; tfound_ff <= tfound_in;
            end
         end
      end
   end

   // A pending result must not be overwritten while the receiver stalls.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !(req_valid && !req_stall && req_word.last))
      else $error("result overwritten while stalled");
   // Each accepted last byte produces a result next cycle.
   a_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.last |=> rsp_valid)
      else $error("missing result");
   // Walk state restarts after a last byte.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.last |=> pos_ff == '0 && !done_ff)
      else $error("walk not restarted");
   // A result with no JPEG type carries no JPEG mode.
   a_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.img_type != IMG_JPEG |-> rsp_word.jpeg_mode == MODE_NONE)
      else $error("mode on non-JPEG result");

endmodule
`default_nettype wire

[bench/format_scoreboard.sv]
// Scoreboard for the image format sniffer: header predictor and result check.
package format_scoreboard_pkg;
   import ifs_pkg::*;

   typedef enum logic [2:0] {
      PH_SEEK, PH_FFRUN, PH_LENHI, PH_LENLO, PH_SKIP, PH_FRAME
   } walk_phase_type;

   localparam int HdrDepth   = 30;
   localparam int ScanWindow = 256;
   localparam int PosCeiling = 511;

   class format_scoreboard;
      rsp_word_type   expected_formats[$];
      int             errors;
      int             results_seen;
      logic [7:0]     hdr[HdrDepth];
      int unsigned    pos;
      walk_phase_type phase;
      logic [15:0]    skip_left;
      logic [7:0]     len_hi;
      int             field_idx;
      jpeg_mode_type  sof_mode;
      logic [15:0]    frame_h;
      logic [15:0]    frame_w;
      bit             walk_done;
      logic [23:0]    tag_shift;
      bit             tag_pending;
      bit             tag_seen;

      function new();
         errors = 0;
         results_seen = 0;
         clear_state();
      endfunction

      function void clear_state();
         foreach (hdr[i]) hdr[i] = 8'h00;
         pos = 0;
         phase = PH_SEEK;
         skip_left = 0;
         len_hi = 0;
         field_idx = 0;
         sof_mode = MODE_NONE;
         frame_h = 0;
         frame_w = 0;
         walk_done = 0;
         tag_shift = 0;
         tag_pending = 0;
         tag_seen = 0;
      endfunction

      function logic [31:0] hb(int unsigned i);
         return (i < HdrDepth) ? {24'h0, hdr[i]} : 32'h0;
      endfunction

      function bit hmatch(int unsigned at, string s);
         for (int k = 0; k < s.len(); k++)
            if (hb(at + k) != {24'h0, s[k]}) return 0;
         return 1;
      endfunction

      function logic [31:0] le16(int unsigned i);
         return hb(i) | (hb(i + 1) << 8);
      endfunction

      function jpeg_mode_type frame_kind(logic [7:0] m);
         if (m == 8'hC0) return MODE_BASELINE;
         if (m == 8'hC2 || m == 8'hCA) return MODE_PROGRESS;
         if (m == 8'hC1 || m == 8'hC9) return MODE_EXTSEQ;
         if (m inside {[8'hC3:8'hC3], [8'hC5:8'hC7], [8'hCB:8'hCB], [8'hCD:8'hCF]})
            return MODE_OTHER;
         return MODE_NONE;
      endfunction

      // JPEG marker walk, one byte at a time, stopping at SOF data, SOS, EOI or a segment length below two.
      function void walk_marker(logic [7:0] b);
         logic [15:0] seg;
         if (walk_done) return;
         case (phase)
            PH_SEEK: if (b == 8'hFF) phase = PH_FFRUN;
            PH_FFRUN: if (b != 8'hFF) begin
               sof_mode = frame_kind(b);
               if (b == 8'hD9 || b == 8'hDA) walk_done = 1;
               else if (b == 8'hD8 || (b >= 8'hD0 && b <= 8'hD7) || b == 8'h00)
                  phase = PH_SEEK;
               else phase = PH_LENHI;
            end
            PH_LENHI: begin
               len_hi = b;
               phase = PH_LENLO;
            end
            PH_LENLO: begin
               seg = {len_hi, b};
               if (seg < 2) begin
                  sof_mode = MODE_NONE;
                  walk_done = 1;
               end else if (sof_mode != MODE_NONE) begin
                  field_idx = 0;
                  phase = PH_FRAME;
               end else begin
                  skip_left = seg - 16'd2;
                  phase = (skip_left != 0) ? PH_SKIP : PH_SEEK;
               end
            end
            PH_SKIP: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 0) phase = PH_SEEK;
            end
            PH_FRAME: begin
               case (field_idx)
                  1: frame_h = {b, 8'h00};
                  2: frame_h = frame_h | {8'h00, b};
                  3: frame_w = {b, 8'h00};
                  4: frame_w = frame_w | {8'h00, b};
                  default: ;
               endcase
               field_idx++;
               if (field_idx >= 5) walk_done = 1;
            end
            default: walk_done = 1;
         endcase
      endfunction

      function rsp_word_type classify_file(int unsigned n);
         rsp_word_type r;
         logic [31:0] raw;
         jpeg_mode_type m;
         r = '0;
         r.img_type = IMG_UNKNOWN;
         r.jpeg_mode = MODE_NONE;
         if (n < 4) begin
            r.img_type = IMG_UNKNOWN;
         end else if (n >= 8 && hb(0) == 32'h89 && hmatch(1, "PNG") && hb(4) == 32'h0D &&
                      hb(5) == 32'h0A && hb(6) == 32'h1A && hb(7) == 32'h0A) begin
            r.img_type = IMG_PNG;
            if (n >= 24 && hmatch(12, "IHDR")) begin
               r.width  = (hb(16) << 24) | (hb(17) << 16) | (hb(18) << 8) | hb(19);
               r.height = (hb(20) << 24) | (hb(21) << 16) | (hb(22) << 8) | hb(23);
            end
         end else if (hb(0) == 32'hFF && hb(1) == 32'hD8 && hb(2) == 32'hFF) begin
            r.img_type = IMG_JPEG;
            m = (sof_mode != MODE_NONE && phase != PH_LENHI && phase != PH_LENLO) ?
                sof_mode : MODE_OTHER;
            r.jpeg_mode = m;
            if ((m != MODE_OTHER || sof_mode == MODE_OTHER) &&
                phase == PH_FRAME && field_idx >= 5) begin
               r.width = {16'h0, frame_w};
               r.height = {16'h0, frame_h};
            end
         end else if (n >= 12 && hmatch(0, "RIFF") && hmatch(8, "WEBP")) begin
            r.img_type = IMG_WEBP;
            if (n >= 30 && hmatch(12, "VP8 ")) begin
               r.width  = le16(26) & 32'h3FFF;
               r.height = le16(28) & 32'h3FFF;
            end else if (n >= 25 && hmatch(12, "VP8L") && hb(20) == 32'h2F) begin
               r.width  = 1 + (((hb(22) & 32'h3F) << 8) | hb(21));
               r.height = 1 + (((hb(24) & 32'hF) << 10) | (hb(23) << 2) |
                               ((hb(22) & 32'hC0) >> 6));
            end else if (n >= 30 && hmatch(12, "VP8X")) begin
               r.width  = 1 + (hb(24) | (hb(25) << 8) | (hb(26) << 16));
               r.height = 1 + (hb(27) | (hb(28) << 8) | (hb(29) << 16));
            end
         end else if (hb(0) == 32'h42 && hb(1) == 32'h4D) begin
            r.img_type = IMG_BMP;
            if (n >= 26) begin
               raw = le16(22) | (le16(24) << 16);
               r.width = le16(18) | (le16(20) << 16);
               r.height = raw[31] ? (32'h0 - raw) : raw;
            end
         end else if (n >= 10 && (hmatch(0, "GIF87a") || hmatch(0, "GIF89a"))) begin
            r.img_type = IMG_GIF;
            r.width = le16(6);
            r.height = le16(8);
         end else if (hmatch(0, "II") && hb(2) == 32'h2A && hb(3) == 0) begin
            r.img_type = IMG_TIFF;
         end else if (hmatch(0, "MM") && hb(2) == 0 && hb(3) == 32'h2A) begin
            r.img_type = IMG_TIFF;
         end else if (n >= 6 && hb(0) == 0 && hb(1) == 0 && hb(2) == 1 && hb(3) == 0) begin
            r.img_type = IMG_ICO;
            if (n >= 8) begin
               r.width  = (hb(6) == 0) ? 32'd256 : hb(6);
               r.height = (hb(7) == 0) ? 32'd256 : hb(7);
            end
         end else if (tag_seen) begin
            r.img_type = IMG_SVG;
         end
         return r;
      endfunction

      function void note_byte(req_word_type w);
         int unsigned p;
         logic [31:0] shifted;
         p = pos;
         if (p < HdrDepth) hdr[p] = w.data_byte;
         if (p >= 2) walk_marker(w.data_byte);
         if (tag_pending) tag_seen = 1;
         shifted = {tag_shift, w.data_byte};
         tag_pending = (shifted == 32'h3C737667 || shifted == 32'h3C535647) &&
                       (p + 1 < ScanWindow);
         tag_shift = shifted[23:0];
         pos = (p < PosCeiling) ? p + 1 : PosCeiling;
         if (w.last) begin
            expected_formats.push_back(classify_file(pos));
            clear_state();
         end
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         results_seen++;
         if (expected_formats.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", got);
            return;
         end
         want = expected_formats.pop_front();
         if (got.img_type !== want.img_type || got.jpeg_mode !== want.jpeg_mode ||
             got.width !== want.width || got.height !== want.height) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected type %0d mode %0d w %0d h %0d, got %0d %0d %0d %0d",
                        want.img_type, want.jpeg_mode, want.width, want.height,
                        got.img_type, got.jpeg_mode, got.width, got.height);
         end
      endfunction
   endclass
endpackage

[bench/tb_top.sv]
// Top-level testbench for the image format sniffer.
module tb_top;
   import ifs_pkg::*;
   import format_scoreboard_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 5000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_word_type rsp_word;

   format_scoreboard sb = new();
   logic [7:0] file_bytes[$];
   int  bytes_sent = 0;
   int  files_sent = 0;
   bit  calm = 0;
   int  quiet_cycles = 0;

   image_format_sniffer uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // The receiver stalls with a probability of 17 percent, except during the calm stretch.
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 17);
   end

   // Both channels are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_word);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_word);
         // The watchdog restarts whenever either channel moves a word.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
               $display("tb_top failed");
               $finish;
            end
         end
      end
   end

   // Send one word, inserting random idle cycles, and wait until it is taken.
   // A stretch of a couple of hundred words runs with no idling on either side.
   task automatic send_word(logic [7:0] b, logic is_last);
      calm = (bytes_sent >= 500 && bytes_sent < 700);
      while (!calm && $urandom_range(99) < 17) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_word.data_byte = b;
      req_word.last = is_last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 0;
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_word(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
      file_bytes.delete();
   endtask

   // Small builders that append to the file under construction.
   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
   endfunction

   function automatic void put_le(logic [31:0] v, int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_be(logic [31:0] v, int n);
      for (int i = n - 1; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_rand(int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void cut_to(int k);
      if (k < 1) k = 1;
      while (file_bytes.size() > k) void'(file_bytes.pop_back());
   endfunction

   function automatic void build_png(bit good_chunk);
      put_be(32'h89504E47, 4);
      put_be(32'h0D0A1A0A, 4);
      put_be($urandom_range(40), 4);
      put_str(good_chunk ? "IHDR" : "IDAT");
      put_be($urandom(), 4);
      put_be($urandom(), 4);
      put_rand($urandom_range(0, 6));
   endfunction

   // A JPEG with optional length-prefixed filler, restart, stuffed and fill markers,
   // per variant an early EOI, short APP1 or SOS, then frame and scan headers and an end marker.
   function automatic void build_jpeg(logic [7:0] frame_marker, int variant);
      int seg;
      put_be(32'hFFD8, 2);
      if ($urandom_range(1)) begin
         seg = $urandom_range(2, 20);
         put_be(seg, 2);
         put_rand(seg - 2);
      end
      if ($urandom_range(3) == 0) put_be(32'hFFD0, 2);
      if ($urandom_range(3) == 0) put_be(32'hFF00, 2);
      if ($urandom_range(3) == 0) put_be(32'hFFFF, 2);
      if (variant == 1) begin
         put_be(32'hFFD9, 2);
      end else if (variant == 2) begin
         put_be(32'hFFE1, 2);
         put_be($urandom_range(1), 2);
      end else if (variant == 3) begin
         put_be(32'hFFDA, 2);
      end
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(frame_marker);
      put_be(32'h0011, 2);
      file_bytes.push_back(8'h08);
      put_be($urandom(), 2);
      put_be($urandom(), 2);
      put_rand(4);
      put_be(32'hFFDA000C, 4);
      put_rand(4);
      put_be(32'hFFD9, 2);
   endfunction

   function automatic void build_webp(int flavor);
      put_str("RIFF");
      put_le($urandom(), 4);
      put_str("WEBP");
      case (flavor)
         0: put_str("VP8 ");
         1: put_str("VP8L");
         2: put_str("VP8X");
         default: put_str("ALPH");
      endcase
      put_rand(4);
      if (flavor == 1)
         file_bytes.push_back($urandom_range(1) ? 8'h2F : 8'($urandom_range(255)));
      put_rand(9 + $urandom_range(4));
   endfunction

   function automatic void build_bmp(logic [31:0] h);
      put_str("BM");
      put_rand(16);
      put_le($urandom(), 4);
      put_le(h, 4);
      put_rand($urandom_range(6));
   endfunction

   function automatic void build_gif(bit is89);
      put_str(is89 ? "GIF89a" : "GIF87a");
      put_le($urandom(), 4);
      put_rand($urandom_range(6));
   endfunction

   function automatic void build_tiff(bit intel);
      if (intel) put_be(32'h49492A00, 4);
      else put_be(32'h4D4D002A, 4);
      put_rand($urandom_range(8));
   endfunction

   function automatic void build_ico(int total, bit zero_dims);
      put_be(32'h00000100, 4);
      put_le(1, 2);
      if (zero_dims) put_be(0, 2);
      else put_rand(2);
      put_rand(10);
      cut_to(total);
   endfunction

   // Text with an SVG-style tag placed at a chosen offset.
   function automatic void build_svg(int at, string tag, int tail);
      for (int i = 0; i < at; i++) file_bytes.push_back(8'($urandom_range(32, 126)));
      put_str(tag);
      put_rand(tail);
   endfunction

   function automatic string pick_tag();
      case ($urandom_range(3))
         0: return "<svg";
         1: return "<SVG";
         2: return "<Svg";
         default: return "<svG";
      endcase
   endfunction

   function automatic logic [7:0] pick_frame_marker();
      logic [7:0] marks[16] = '{8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hC7, 8'hC9,
                                8'hCA, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hC4, 8'hC8, 8'hCC};
      return marks[$urandom_range(15)];
   endfunction

   initial begin
      int kind;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed files: short files, every format and its corner cases.
      for (int k = 1; k <= 3; k++) begin
         put_rand(k);
         send_file();
      end
      build_png(1); send_file();
      build_png(0); send_file();
      build_jpeg(8'hC0, 0); send_file();
      build_jpeg(8'hC2, 0); send_file();
      build_jpeg(8'hCA, 0); send_file();
      build_jpeg(8'hC9, 0); send_file();
      build_jpeg(8'hCF, 0); send_file();
      build_jpeg(8'hC0, 1); send_file();
      build_jpeg(8'hC0, 2); send_file();
      // Frame header cut after its precision byte and after its height field.
      build_jpeg(8'hC1, 0); cut_to(file_bytes.size() - 18); send_file();
      build_jpeg(8'hC0, 0); cut_to(file_bytes.size() - 16); send_file();
      for (int f = 0; f < 4; f++) begin
         build_webp(f); send_file();
      end
      build_bmp(32'h80000000); send_file();
      build_bmp(32'hFFFFFF00); send_file();
      build_gif(0); send_file();
      build_gif(1); send_file();
      build_tiff(1); send_file();
      build_tiff(0); send_file();
      build_ico(8, 1); send_file();
      build_ico(7, 0); send_file();
      build_svg(3, "<svg", 1); send_file();
      build_svg(251, "<SVG", 4); send_file();
      build_svg(252, "<svg", 4); send_file();
      build_svg(5, "<Svg", 2); send_file();
      repeat (20) file_bytes.push_back(8'hFF);
      send_file();

      // Random files: mostly well-formed with random content, some cut short,
      // the rest noise.
      while (bytes_sent < 1100) begin
         kind = $urandom_range(11);
         case (kind)
            0: build_png($urandom_range(3) != 0);
            1, 2: build_jpeg(pick_frame_marker(), $urandom_range(3) == 0 ?
                             $urandom_range(1, 3) : 0);
            3: build_webp($urandom_range(3));
            4: build_bmp($urandom_range(1) ? $urandom() : -$urandom_range(1000));
            5: build_gif($urandom_range(1));
            6: build_tiff($urandom_range(1));
            7: build_ico($urandom_range(4, 12), $urandom_range(1));
            8: build_svg($urandom_range(3) == 0 ? $urandom_range(245, 258) :
                         $urandom_range(20), pick_tag(), $urandom_range(3));
            9: put_rand($urandom_range(1, 3));
            default: put_rand($urandom_range(1, 40));
         endcase
         if ($urandom_range(3) == 0) cut_to($urandom_range(1, file_bytes.size()));
         send_file();
      end
      calm = 0;

      // Drain the pending results, then allow the output register to settle.
      while (sb.expected_formats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_formats.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule

[image_format_sniffer.f]
hw/rtl/ifs_pkg.sv
hw/rtl/image_format_sniffer.sv
bench/format_scoreboard.sv
bench/tb_top.sv
